@@ hw/rtl/ghc_pkg.sv @@
// shared constants, codes and types of the graph hill climbing core
`default_nettype none
package ghc_pkg;

  localparam int unsigned MaxNodes = 16;
  localparam int unsigned NodeW    = 4;
  localparam int unsigned CountW   = 5;
  localparam int unsigned RowW     = 16;
  localparam int unsigned HeurW    = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned KindW    = 3;

  localparam logic [HeurW-1:0] HeurTop = {1'b0, {(HeurW-1){1'b1}}};
  localparam logic [CountW-1:0] CountMax = CountW'(MaxNodes);

  localparam logic [CmdW-1:0] CmdLoadAdj  = 2'd0;
  localparam logic [CmdW-1:0] CmdLoadHeur = 2'd1;
  localparam logic [CmdW-1:0] CmdStart    = 2'd2;

  typedef enum logic [KindW-1:0] {
    EvStart    = 3'd0,
    EvMove     = 3'd1,
    EvNoNbr    = 3'd2,
    EvPeak     = 3'd3,
    EvBadStart = 3'd4
  } event_kind_e;

  typedef struct packed {
    logic [NodeW-1:0]        node_id;
    logic signed [HeurW-1:0] node_heuristic;
    event_kind_e             event_kind;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic             valid;
    out_word_t        word;
  } emit_t;

  typedef struct packed {
    logic             re;
    logic [NodeW-1:0] addr;
  } rd_req_t;

endpackage
`default_nettype wire

@@ hw/rtl/ghc_if.sv @@
// valid/ready channel interfaces of the graph hill climbing core
`default_nettype none
interface ghc_in_if import ghc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         command;
  logic [NodeW-1:0]        node_index;
  logic [RowW-1:0]         adjacency_row;
  logic signed [HeurW-1:0] heuristic_value;
  modport source (output valid, command, node_index, adjacency_row, heuristic_value,
                  input ready);
  modport sink (input valid, command, node_index, adjacency_row, heuristic_value,
                output ready);
endinterface

interface ghc_out_if import ghc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [NodeW-1:0]        node_id;
  logic signed [HeurW-1:0] node_heuristic;
  logic [KindW-1:0]        event_kind;
  logic                    last;
  modport source (output valid, node_id, node_heuristic, event_kind, last, input ready);
  modport sink (input valid, node_id, node_heuristic, event_kind, last, output ready);
endinterface

interface ghc_cfg_if import ghc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ghc_ram.sv @@
// generic single write port, single read port ram with registered read data
`default_nettype none
module ghc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ hw/rtl/ghc_climb_fsm.sv @@
// climb sequencer: fetches the current node, scans neighbours, decides the next move
`default_nettype none
module ghc_climb_fsm import ghc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [NodeW-1:0]        start_node_i,
  input  wire logic [CountW-1:0]       n_eff_i,
  input  wire logic                    slot_free_i,
  input  wire logic [RowW-1:0]         adj_rdata_i,
  input  wire logic signed [HeurW-1:0] heur_rdata_i,
  output rd_req_t                      adj_rd_o,
  output rd_req_t                      heur_rd_o,
  output emit_t                        emit_o,
  output logic                         idle_o
);

  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SFetch  = 6'b000010,
    SEmit   = 6'b000100,
    SScan   = 6'b001000,
    SDrain  = 6'b010000,
    SDecide = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  logic [NodeW-1:0]        cur_q, cur_d;
  logic signed [HeurW-1:0] hcur_q, hcur_d;
  logic [RowW-1:0]         row_q, row_d;
  logic [MaxNodes-1:0]     visited_q, visited_d;
  logic [NodeW-1:0]        scan_q, scan_d;
  logic [NodeW-1:0]        chk_idx_q, chk_idx_d;
  logic                    chk_vld_q, chk_vld_d;
  logic [NodeW-1:0]        best_q, best_d;
  logic signed [HeurW-1:0] best_h_q, best_h_d;
  logic                    found_q, found_d;
  event_kind_e             kind_q, kind_d;
  logic [CountW-1:0]       last_idx;

  assign last_idx = n_eff_i - CountW'(1);
  assign idle_o   = (state_q == SIdle);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    hcur_d    = hcur_q;
    row_d     = row_q;
    visited_d = visited_q;
    scan_d    = scan_q;
    chk_idx_d = chk_idx_q;
    chk_vld_d = 1'b0;
    best_d    = best_q;
    best_h_d  = best_h_q;
    found_d   = found_q;
    kind_d    = kind_q;
    adj_rd_o  = '0;
    heur_rd_o = '0;
    emit_o    = '0;

    if (chk_vld_q && row_q[chk_idx_q] && !visited_q[chk_idx_q] &&
        (heur_rdata_i < best_h_q)) begin
      best_d   = chk_idx_q;
      best_h_d = heur_rdata_i;
      found_d  = 1'b1;
    end

    case (state_q)
      SIdle: begin
        if (start_i) begin
          if ({1'b0, start_node_i} >= n_eff_i) begin
            emit_o.valid               = 1'b1;
            emit_o.word.node_id        = start_node_i;
            emit_o.word.node_heuristic = '0;
            emit_o.word.event_kind     = EvBadStart;
            emit_o.word.last           = 1'b1;
          end else begin
            cur_d          = start_node_i;
            visited_d      = MaxNodes'(1) << start_node_i;
            adj_rd_o.re    = 1'b1;
            adj_rd_o.addr  = start_node_i;
            heur_rd_o.re   = 1'b1;
            heur_rd_o.addr = start_node_i;
            kind_d         = EvStart;
            state_d        = SFetch;
          end
        end
      end
      SFetch: begin
        hcur_d  = heur_rdata_i;
        row_d   = adj_rdata_i;
        state_d = SEmit;
      end
      SEmit: begin
        if (slot_free_i) begin
          emit_o.valid               = 1'b1;
          emit_o.word.node_id        = cur_q;
          emit_o.word.node_heuristic = hcur_q;
          emit_o.word.event_kind     = kind_q;
          emit_o.word.last           = 1'b0;
          best_h_d       = HeurTop;
          found_d        = 1'b0;
          heur_rd_o.re   = 1'b1;
          heur_rd_o.addr = '0;
          chk_vld_d      = 1'b1;
          chk_idx_d      = '0;
          if (last_idx == '0) begin
            state_d = SDrain;
          end else begin
            scan_d  = NodeW'(1);
            state_d = SScan;
          end
        end
      end
      SScan: begin
        heur_rd_o.re   = 1'b1;
        heur_rd_o.addr = scan_q;
        chk_vld_d      = 1'b1;
        chk_idx_d      = scan_q;
        if ({1'b0, scan_q} == last_idx) begin
          state_d = SDrain;
        end else begin
          scan_d = scan_q + NodeW'(1);
        end
      end
      SDrain: begin
        state_d = SDecide;
      end
      SDecide: begin
        if (slot_free_i) begin
          if (!found_q || !(best_h_q < hcur_q)) begin
            emit_o.valid               = 1'b1;
            emit_o.word.node_id        = cur_q;
            emit_o.word.node_heuristic = hcur_q;
            emit_o.word.event_kind     = found_q ? EvPeak : EvNoNbr;
            emit_o.word.last           = 1'b1;
            state_d                    = SIdle;
          end else begin
            visited_d      = visited_q | (MaxNodes'(1) << best_q);
            cur_d          = best_q;
            adj_rd_o.re    = 1'b1;
            adj_rd_o.addr  = best_q;
            heur_rd_o.re   = 1'b1;
            heur_rd_o.addr = best_q;
            kind_d         = EvMove;
            state_d        = SFetch;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cur_q     <= '0;
      visited_q <= '0;
      chk_vld_q <= 1'b0;
      found_q   <= 1'b0;
      kind_q    <= EvStart;
      scan_q    <= '0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      visited_q <= visited_d;
      chk_vld_q <= chk_vld_d;
      found_q   <= found_d;
      kind_q    <= kind_d;
      scan_q    <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hcur_q    <= hcur_d;
    row_q     <= row_d;
    chk_idx_q <= chk_idx_d;
    best_q    <= best_d;
    best_h_q  <= best_h_d;
  end

endmodule
`default_nettype wire

@@ hw/rtl/graph_hill_climb_core.sv @@
// top level of the graph hill climbing core: stores, node count register, result register
// Loads of an adjacency row or a heuristic write the row and heuristic memories directly.
// A start climb, for each node visited, captures the node's row and heuristic, sends its
// word while the heuristic of node 0 is read, then reads the heuristic of each further
// candidate through the single read port, drains and decides; sending and deciding wait
// while the output register is full. A start at or beyond the node count answers with
// one error result. Results leave through a one-word output register; the next word is
// only produced once the register is free, and a new command is taken only while the
// climb is idle and the register is empty or being read in the same cycle. Node count
// writes are taken in any cycle.
`default_nettype none
module graph_hill_climb_core import ghc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ghc_in_if.sink    in_i,
  ghc_out_if.source out_o,
  ghc_cfg_if.sink   cfg_i
);

  logic [CountW-1:0]       node_count_q;
  logic [CountW-1:0]       n_eff;
  logic                    slot_free;
  logic                    idle;
  logic                    in_acc;
  logic                    adj_we;
  logic                    heur_we;
  logic [RowW-1:0]         adj_rdata;
  logic [HeurW-1:0]        heur_rdata;
  rd_req_t                 adj_rd;
  rd_req_t                 heur_rd;
  emit_t                   emit;
  logic                    out_vld_q;
  out_word_t               out_word_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CountMax;
    end else if (cfg_i.valid) begin
      node_count_q <= cfg_i.data;
    end
  end

  assign n_eff = (node_count_q > CountMax) ? CountMax : node_count_q;

  assign slot_free   = !out_vld_q || out_o.ready;
  assign in_i.ready  = idle && slot_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign adj_we      = in_acc && (in_i.command == CmdLoadAdj);
  assign heur_we     = in_acc && (in_i.command == CmdLoadHeur);

  ghc_ram #(.Width(RowW), .Depth(MaxNodes)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (in_i.node_index),
    .wdata_i (in_i.adjacency_row),
    .re_i    (adj_rd.re),
    .raddr_i (adj_rd.addr),
    .rdata_o (adj_rdata)
  );

  ghc_ram #(.Width(HeurW), .Depth(MaxNodes)) u_heur_ram (
    .clk_i   (clk_i),
    .we_i    (heur_we),
    .waddr_i (in_i.node_index),
    .wdata_i (in_i.heuristic_value),
    .re_i    (heur_rd.re),
    .raddr_i (heur_rd.addr),
    .rdata_o (heur_rdata)
  );

  ghc_climb_fsm u_climb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_acc && (in_i.command == CmdStart)),
    .start_node_i (in_i.node_index),
    .n_eff_i      (n_eff),
    .slot_free_i  (slot_free),
    .adj_rdata_i  (adj_rdata),
    .heur_rdata_i (heur_rdata),
    .adj_rd_o     (adj_rd),
    .heur_rd_o    (heur_rd),
    .emit_o       (emit),
    .idle_o       (idle)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit.valid) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_word_q <= emit.word;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.node_id        = out_word_q.node_id;
  assign out_o.node_heuristic = out_word_q.node_heuristic;
  assign out_o.event_kind     = out_word_q.event_kind;
  assign out_o.last           = out_word_q.last;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// testbench of graph_hill_climb_core: directed and random load/climb traffic checked word by word
`timescale 1ns / 1ps
module tb_top;
  import ghc_pkg::*;

  localparam logic [CmdW-1:0] CmdIgnore = 2'd3;
  localparam int WatchLimit   = 4000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 40;

  typedef struct packed {
    logic [CmdW-1:0]         command;
    logic [NodeW-1:0]        node_index;
    logic [RowW-1:0]         adjacency_row;
    logic signed [HeurW-1:0] heuristic_value;
  } climb_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ghc_in_if  in_if ();
  ghc_out_if out_if ();
  ghc_cfg_if cfg_if ();

  graph_hill_climb_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // graph image and node count as the block should hold them
  logic [RowW-1:0]         adj_mem [MaxNodes];
  logic signed [HeurW-1:0] heur_mem [MaxNodes];
  logic [CountW-1:0]       walk_count;
  out_word_t               climb_trail [$];

  // stimulus side
  climb_cmd_t        cmd_backlog [$];
  climb_cmd_t        next_cmd;
  climb_cmd_t        seen_cmd;
  logic [CountW-1:0] gen_count;
  logic [MaxNodes-1:0] adj_written;
  logic [MaxNodes-1:0] heur_written;
  int cmds_queued;
  int cmds_taken;
  int bad_fields;
  int send_gap;
  int stall_left;
  int hold_left;
  int idle_cycles;
  bit hold_req;
  bit in_sent;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_step(input logic [NodeW-1:0] id,
                                    input logic signed [HeurW-1:0] h,
                                    input event_kind_e kind, input logic fin);
    out_word_t w;
    w.node_id        = id;
    w.node_heuristic = h;
    w.event_kind     = kind;
    w.last           = fin;
    climb_trail.push_back(w);
  endfunction

  task automatic advance_walker(input climb_cmd_t c);
    int live;
    int i;
    logic [NodeW-1:0]        here;
    logic [NodeW-1:0]        best;
    logic [MaxNodes-1:0]     seen;
    logic signed [HeurW-1:0] best_h;
    bit found;
    bit done;
    live = (walk_count > CountMax) ? MaxNodes : walk_count;
    case (c.command)
      CmdLoadAdj: begin
        adj_mem[c.node_index] = c.adjacency_row;
      end
      CmdLoadHeur: begin
        heur_mem[c.node_index] = c.heuristic_value;
      end
      CmdStart: begin
        if (c.node_index >= live) begin
          note_step(c.node_index, '0, EvBadStart, 1'b1);
        end else begin
          here = c.node_index;
          seen = '0;
          seen[here] = 1'b1;
          note_step(here, heur_mem[here], EvStart, 1'b0);
          done = 1'b0;
          while (!done) begin
            found  = 1'b0;
            best   = '0;
            best_h = HeurTop;
            for (i = 0; i < live; i++) begin
              if (adj_mem[here][i] && !seen[i] && heur_mem[i] < best_h) begin
                best_h = heur_mem[i];
                best   = NodeW'(i);
                found  = 1'b1;
              end
            end
            if (!found) begin
              note_step(here, heur_mem[here], EvNoNbr, 1'b1);
              done = 1'b1;
            end else if (best_h >= heur_mem[here]) begin
              note_step(here, heur_mem[here], EvPeak, 1'b1);
              done = 1'b1;
            end else begin
              seen[best] = 1'b1;
              here = best;
              note_step(here, heur_mem[here], EvMove, 1'b0);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_cmd(input logic [CmdW-1:0] op, input logic [NodeW-1:0] idx,
                          input logic [RowW-1:0] row, input logic signed [HeurW-1:0] h);
    climb_cmd_t c;
    c.command         = op;
    c.node_index      = idx;
    c.adjacency_row   = row;
    c.heuristic_value = h;
    if (op == CmdLoadAdj) adj_written[idx] = 1'b1;
    if (op == CmdLoadHeur) heur_written[idx] = 1'b1;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endtask

  function automatic logic [RowW-1:0] rand_row();
    case ($urandom_range(0, 5))
      0: return 16'hffff;
      1: return 16'h0000;
      default: return RowW'($urandom);
    endcase
  endfunction

  function automatic logic signed [HeurW-1:0] rand_heur();
    case ($urandom_range(0, 9))
      0: return HeurTop;
      1: return 32'sh8000_0000;
      2, 3: return $urandom;
      default: return HeurW'($urandom_range(0, 40)) - 32'sd20;
    endcase
  endfunction

  function automatic bit graph_loaded();
    logic [MaxNodes-1:0] mask;
    mask = (gen_count >= CountMax) ? '1 : ((MaxNodes'(1) << gen_count) - 1'b1);
    return ((adj_written & mask) == mask) && ((heur_written & mask) == mask);
  endfunction

  task automatic queue_random(input int count);
    int n;
    int r;
    int i;
    logic [NodeW-1:0] idx;
    for (n = 0; n < count; n++) begin
      r   = $urandom_range(0, 99);
      idx = NodeW'($urandom_range(0, 15));
      if (r < 30) begin
        push_cmd(CmdLoadAdj, idx, rand_row(), $urandom);
      end else if (r < 55) begin
        push_cmd(CmdLoadHeur, idx, RowW'($urandom), rand_heur());
      end else if (r < 95) begin
        if (gen_count < CountMax && $urandom_range(0, 4) == 0) begin
          push_cmd(CmdStart, NodeW'($urandom_range(gen_count, 15)), RowW'($urandom),
                   $urandom);
        end else if (graph_loaded()) begin
          push_cmd(CmdStart, NodeW'($urandom_range(0, gen_count - 1)), RowW'($urandom),
                   $urandom);
        end else begin
          // fill in a row or value the climb would read
          for (i = 0; i < MaxNodes; i++) begin
            if (!adj_written[i]) begin
              push_cmd(CmdLoadAdj, NodeW'(i), rand_row(), $urandom);
              break;
            end else if (!heur_written[i]) begin
              push_cmd(CmdLoadHeur, NodeW'(i), RowW'($urandom), rand_heur());
              break;
            end
          end
        end
      end else begin
        push_cmd(CmdIgnore, idx, RowW'($urandom), $urandom);
      end
    end
  endtask

  // strictly falling chain through all nodes in use, so a climb visits every one
  task automatic queue_chain();
    int order [MaxNodes];
    int live;
    int k;
    int j;
    int tmp;
    logic signed [HeurW-1:0] val;
    logic [RowW-1:0] row;
    logic [RowW-1:0] above;
    live = (gen_count > CountMax) ? MaxNodes : gen_count;
    for (k = 0; k < MaxNodes; k++) order[k] = k;
    for (k = live - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    val   = $urandom_range(0, 1000000);
    above = '0;
    for (k = 0; k < live; k++) begin
      row = RowW'($urandom) & above;
      if (k < live - 1) row[order[k + 1]] = 1'b1;
      push_cmd(CmdLoadAdj, NodeW'(order[k]), row, $urandom);
      push_cmd(CmdLoadHeur, NodeW'(order[k]), RowW'($urandom), val);
      above[order[k]] = 1'b1;
      val = val - HeurW'($urandom_range(1, 1000));
    end
    push_cmd(CmdStart, NodeW'(order[0]), RowW'($urandom), $urandom);
    push_cmd(CmdStart, NodeW'($urandom_range(0, live - 1)), RowW'($urandom), $urandom);
    push_cmd(CmdStart, NodeW'(order[live / 2]), RowW'($urandom), $urandom);
  endtask

  task automatic write_node_count(input logic [CountW-1:0] v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    walk_count = v;
    gen_count  = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic settle();
    while (cmds_taken != cmds_queued || climb_trail.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // command driver
  always @(negedge clk_i) begin
    if (!in_if.valid || in_sent) begin
      in_sent = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_if.valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        next_cmd = cmd_backlog.pop_front();
        in_if.command         <= next_cmd.command;
        in_if.node_index      <= next_cmd.node_index;
        in_if.adjacency_row   <= next_cmd.adjacency_row;
        in_if.heuristic_value <= next_cmd.heuristic_value;
        in_if.valid           <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls and one long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // monitor
  out_word_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        in_sent = 1'b1;
        cmds_taken++;
        seen_cmd.command         = in_if.command;
        seen_cmd.node_index      = in_if.node_index;
        seen_cmd.adjacency_row   = in_if.adjacency_row;
        seen_cmd.heuristic_value = in_if.heuristic_value;
        advance_walker(seen_cmd);
      end
      if (out_if.valid && out_if.ready) begin
        if (climb_trail.size() == 0) begin
          $error("unexpected result word: node_id %0d event_kind %0d",
                 out_if.node_id, out_if.event_kind);
          bad_fields++;
        end else begin
          want = climb_trail.pop_front();
          if (out_if.node_id !== want.node_id) begin
            $error("node_id: expected %0d, actual %0d", want.node_id, out_if.node_id);
            bad_fields++;
          end
          if (out_if.node_heuristic !== want.node_heuristic) begin
            $error("node_heuristic: expected %0d, actual %0d",
                   want.node_heuristic, out_if.node_heuristic);
            bad_fields++;
          end
          if (out_if.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, actual %0d", want.event_kind, out_if.event_kind);
            bad_fields++;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_if.last);
            bad_fields++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    in_if.valid           = 1'b0;
    in_if.command         = '0;
    in_if.node_index      = '0;
    in_if.adjacency_row   = '0;
    in_if.heuristic_value = '0;
    out_if.ready          = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.data           = '0;
    walk_count   = CountMax;
    gen_count    = CountMax;
    adj_written  = '0;
    heur_written = '0;
    cmds_queued  = 0;
    cmds_taken   = 0;
    bad_fields   = 0;
    send_gap     = 0;
    stall_left   = 0;
    hold_left    = 0;
    idle_cycles  = 0;
    hold_req     = 1'b0;
    in_sent      = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // four-node graph: ties, top value, peaks, dead ends, bad starts
    write_node_count(5'd4);
    push_cmd(CmdLoadAdj, 4'd0, 16'hfffa, '0);
    push_cmd(CmdLoadAdj, 4'd1, 16'h000c, '0);
    push_cmd(CmdLoadAdj, 4'd2, 16'h0000, '0);
    push_cmd(CmdLoadAdj, 4'd3, 16'h0002, '0);
    push_cmd(CmdLoadHeur, 4'd0, '0, 32'sd100);
    push_cmd(CmdLoadHeur, 4'd1, '0, 32'sd50);
    push_cmd(CmdLoadHeur, 4'd2, '0, 32'sh8000_0000);
    push_cmd(CmdLoadHeur, 4'd3, '0, 32'sd50);
    push_cmd(CmdStart, 4'd0, '0, '0);
    push_cmd(CmdStart, 4'd3, '0, '0);
    push_cmd(CmdLoadHeur, 4'd2, '0, HeurTop);
    push_cmd(CmdStart, 4'd1, '0, '0);
    push_cmd(CmdStart, 4'd4, '0, '0);
    push_cmd(CmdStart, 4'd15, 16'hffff, 32'sh7fff_ffff);
    push_cmd(CmdIgnore, 4'd15, 16'hffff, -32'sd1);
    push_cmd(CmdLoadAdj, 4'd15, 16'hffff, '0);
    push_cmd(CmdLoadHeur, 4'd15, '0, -32'sd1);
    push_cmd(CmdLoadHeur, 4'd1, '0, 32'sd40);
    push_cmd(CmdStart, 4'd3, '0, '0);
    push_cmd(CmdStart, 4'd2, '0, '0);
    settle();

    write_node_count(5'd1);
    push_cmd(CmdStart, 4'd0, '0, '0);
    push_cmd(CmdStart, 4'd1, '0, '0);
    push_cmd(CmdIgnore, 4'd0, '0, '0);
    settle();

    // full graph, long climbs with the result side held off
    write_node_count(5'd16);
    queue_chain();
    hold_req = 1'b1;
    settle();
    queue_random(25);
    settle();

    write_node_count(CountW'($urandom_range(2, 14)));
    queue_random(20);
    settle();

    write_node_count(5'd15);
    queue_random(10);
    settle();

    if (bad_fields == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
